[rtl/core/umpq_pkg.sv]
// ----------------------------------------------------------------------------
// umpq_pkg
// Types and codes shared by the unsorted max priority queue core.
// ----------------------------------------------------------------------------
package umpq_pkg;

   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [1:0] req_type;
      value_type  value;
   } req_item_type;

   typedef struct packed {
      logic      ok;
      value_type removed_value;
      logic      is_empty;
   } rsp_item_type;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic shift;
      logic insert;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_SHIFT
   } state_type;

endpackage

[rtl/core/umpq_cell.sv]
// ----------------------------------------------------------------------------
// umpq_cell
// One slot of the queue chain. Loads a new entry, or moves one place
// towards the head, taking either its upper neighbour or the head wrap-around.
// ----------------------------------------------------------------------------
module umpq_cell (
   input  logic                   clock,
   input  umpq_pkg::cell_ctl_type ctl,
   input  logic                   sel,
   input  umpq_pkg::value_type    ins_value,
   input  umpq_pkg::value_type    head_value,
   input  umpq_pkg::value_type    upper_value,
   output umpq_pkg::value_type    value
);

   umpq_pkg::value_type value_ff;
   umpq_pkg::value_type value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.insert && sel) begin
         value_in = ins_value;
      end else if (ctl.shift) begin
         value_in = sel ? head_value : upper_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[rtl/core/umpq_ctrl.sv]
// ----------------------------------------------------------------------------
// umpq_ctrl
// Request sequencer: entry count, maximum scan over the rotating chain,
// removal pass and result register.
// ----------------------------------------------------------------------------
module umpq_ctrl #(
   parameter int CAPACITY = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  umpq_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   output umpq_pkg::rsp_item_type rsp_data,
   input  umpq_pkg::value_type    head_value,
   output umpq_pkg::cell_ctl_type cell_ctl,
   output logic [CAPACITY-1:0]    cell_sel
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   umpq_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          step_ff, step_in;
   logic [IW-1:0]          best_idx_ff, best_idx_in;
   logic [IW-1:0]          pick_ff, pick_in;
   umpq_pkg::value_type    head_ff, head_in;
   umpq_pkg::value_type    best_ff, best_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   umpq_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                   wr_en;
   logic [CW-1:0]          wr_pos;
   logic                   last_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= umpq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      best_idx_ff <= best_idx_in;
      pick_ff     <= pick_in;
      head_ff     <= head_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
   end

   assign last_step = (CW'(step_ff) == count_ff - CW'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      best_idx_in  = best_idx_ff;
      pick_in      = pick_ff;
      head_in      = head_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cell_ctl     = '0;
      wr_en        = 1'b0;
      wr_pos       = count_ff - CW'(1);

      case (state_ff)
         umpq_pkg::ST_IDLE: begin
            if (start) begin
               rsp_in.ok            = 1'b0;
               rsp_in.removed_value = '0;
               case (req_data.req_type)
                  umpq_pkg::REQ_INSERT: begin
                     if (count_ff < CW'(CAPACITY)) begin
                        cell_ctl.insert = 1'b1;
                        wr_en           = 1'b1;
                        wr_pos          = count_ff;
                        count_in        = count_ff + CW'(1);
                        rsp_in.ok       = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  umpq_pkg::REQ_REMOVE: begin
                     if (count_ff != '0) begin
                        state_in = umpq_pkg::ST_SCAN;
                        step_in  = '0;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  umpq_pkg::REQ_CLEAR: begin
                     count_in     = '0;
                     rsp_in.ok    = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               rsp_in.is_empty = (count_in == '0);
            end
         end

         umpq_pkg::ST_SCAN: begin
            // full rotation: each entry passes the head once, order restored
            cell_ctl.shift = 1'b1;
            wr_en          = 1'b1;
            if (step_ff == '0) begin
               head_in = head_value;
            end else if (step_ff == IW'(1)) begin
               best_in     = head_value;
               best_idx_in = step_ff;
            end else if (head_value > best_ff) begin
               best_in     = head_value;
               best_idx_in = step_ff;
            end
            if (last_step) begin
               state_in = umpq_pkg::ST_PICK;
            end else begin
               step_in = step_ff + IW'(1);
            end
         end

         umpq_pkg::ST_PICK: begin
            // head wins only when strictly above every later entry
            if (count_ff == CW'(1) || head_ff > best_ff) begin
               pick_in              = '0;
               rsp_in.removed_value = head_ff;
            end else begin
               pick_in              = best_idx_ff;
               rsp_in.removed_value = best_ff;
            end
            step_in  = '0;
            state_in = umpq_pkg::ST_SHIFT;
         end

         umpq_pkg::ST_SHIFT: begin
            // second rotation; the picked entry is not wrapped back
            cell_ctl.shift = 1'b1;
            if (step_ff != pick_ff) begin
               wr_en = 1'b1;
               if (step_ff > pick_ff) begin
                  wr_pos = count_ff - CW'(2);
               end
            end
            if (last_step) begin
               count_in        = count_ff - CW'(1);
               rsp_in.ok       = 1'b1;
               rsp_in.is_empty = (count_in == '0);
               rsp_valid_in    = 1'b1;
               state_in        = umpq_pkg::ST_IDLE;
            end else begin
               step_in = step_ff + IW'(1);
            end
         end

         default: begin
            state_in = umpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_sel[i] = wr_en && (wr_pos == CW'(i));
      end
   end

   assign busy      = (state_ff != umpq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/unsorted_max_priority_queue_core.sv]
// Insert, clear, failed requests: result in the cycle after the transfer, busy stays low.
// Remove: busy through the scan rotation, the pick state and the removal rotation, each
// rotation passing every entry; the result shows in the same cycle that busy falls.
// A new request is taken in the cycle its predecessor's result shows.
// Reset empties the queue and drops any pending result; slot contents are not cleared.
// ----------------------------------------------------------------------------
// unsorted_max_priority_queue_core
// Bounded queue of signed values in arrival order, built as a chain of cells
// that rotates towards the head; remove takes out the maximum.
// ----------------------------------------------------------------------------
module unsorted_max_priority_queue_core #(
   parameter int CAPACITY = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  umpq_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   output umpq_pkg::rsp_item_type rsp_data
);

   umpq_pkg::cell_ctl_type cell_ctl;
   logic [CAPACITY-1:0]    cell_sel;
   umpq_pkg::value_type    cell_value [CAPACITY];

   umpq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .head_value (cell_value[0]),
      .cell_ctl   (cell_ctl),
      .cell_sel   (cell_sel)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      umpq_pkg::value_type upper;
      if (i == CAPACITY - 1) begin : g_top
         assign upper = cell_value[i];
      end else begin : g_mid
         assign upper = cell_value[i+1];
      end
      umpq_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .sel         (cell_sel[i]),
         .ins_value   (req_data.value),
         .head_value  (cell_value[0]),
         .upper_value (upper),
         .value       (cell_value[i])
      );
   end

endmodule

[rtl/core/umpq_checker.sv]
// ----------------------------------------------------------------------------
// umpq_checker
// Port-level checks of the queue core, bound to the top level.
// ----------------------------------------------------------------------------
module umpq_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input umpq_pkg::req_item_type req_data,
   input logic                   rsp_valid,
   input umpq_pkg::rsp_item_type rsp_data
);

   // a result never shows while a remove is still in progress
   a_rsp_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // every result is caused by a transfer or by the end of a busy period
   a_rsp_caused : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start || busy))
      else $error("result without a request");

   a_clear : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.req_type == umpq_pkg::REQ_CLEAR)
      |=> (rsp_valid && rsp_data.ok && rsp_data.is_empty && rsp_data.removed_value == '0))
      else $error("clear result wrong");

   a_insert : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.req_type == umpq_pkg::REQ_INSERT)
      |=> (rsp_valid && rsp_data.removed_value == '0 && (!rsp_data.ok || !rsp_data.is_empty)))
      else $error("insert result wrong");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> rsp_data.removed_value == '0)
      else $error("failed request reports a value");

endmodule

bind unsorted_max_priority_queue_core umpq_checker u_checker (.*);
